[sv/itoa_pkg.sv]
// shared constants, types and helpers for the integer to radix ascii converter
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int DIGIT_W    = 6;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int NUMBER_W   = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] MIN_RADIX   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] MAX_RADIX   = RADIX_W'(36);
    localparam logic [CHAR_W-1:0]  MINUS_CODE  = CHAR_W'(45);
    localparam logic [CHAR_W-1:0]  EMPTY_CODE  = CHAR_W'(0);
    localparam logic [CHAR_W-1:0]  ZERO_CODE   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ALPHA_BASE  = CHAR_W'(87);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } itoa_state_t;

    // one digit per divide step, done when the quotient reaches zero
    typedef struct packed {
        logic               digit_valid;
        logic               done;
        logic [DIGIT_W-1:0] digit;
    } itoa_div_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] base;
        base = (d < DIGIT_W'(10)) ? ZERO_CODE : ALPHA_BASE;
        return base + {1'b0, d};
    endfunction

endpackage

[sv/itoa_div_serial.sv]
// bit-serial repeated divider: peels off one remainder digit per pass over the value
`timescale 1ns / 1ps

module itoa_div_serial (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [itoa_pkg::VALUE_BITS-1:0]      value,
    input  logic [itoa_pkg::RADIX_W-1:0]         radix,
    output itoa_pkg::itoa_div_status_t           status
);
    import itoa_pkg::*;

    logic                  busy_reg, busy_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]      bit_cnt_reg, bit_cnt_next;

    logic [DIGIT_W:0]      trial;
    logic [DIGIT_W:0]      diff;
    logic                  fits;
    logic [DIGIT_W-1:0]    rem_new;
    logic [VALUE_BITS-1:0] quot_new;
    logic                  last_bit;

    // restoring division, one dividend bit per cycle
    assign trial    = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign fits     = trial >= {1'b0, radix};
    assign diff     = trial - {1'b0, radix};
    assign rem_new  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    assign quot_new = {quot_reg[VALUE_BITS-2:0], fits};
    assign last_bit = bit_cnt_reg == IDX_W'(VALUE_BITS - 1);

    always_comb
    begin
        busy_next    = busy_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        status       = '0;
        if (start)
        begin
            busy_next    = 1'b1;
            quot_next    = value;
            rem_next     = '0;
            bit_cnt_next = '0;
        end
        else if (busy_reg)
        begin
            quot_next    = quot_new;
            rem_next     = rem_new;
            bit_cnt_next = bit_cnt_reg + IDX_W'(1);
            if (last_bit)
            begin
                status.digit_valid = 1'b1;
                status.digit       = rem_new;
                status.done        = quot_new == '0;
                rem_next           = '0;
                bit_cnt_next       = '0;
                busy_next          = quot_new != '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            quot_reg    <= '0;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            quot_reg    <= quot_next;
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |=> !busy_reg)
        else $error("divider still busy after last digit");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < radix)
        else $error("partial remainder reached the radix");

endmodule

[sv/integer_to_radix_ascii_top.sv]
// top level: signed integer to ascii string in a configurable radix
`timescale 1ns / 1ps

// channel  | dir | handshake           | payload
// ---------+-----+---------------------+------------------------------------
// input    | in  | in_valid / in_stall | number[31:0] signed
// output   | out | out_valid/out_stall | char_code[6:0], is_last, is_empty
// config   | in  | cfg_wr_en           | cfg_wr_data[5:0] = radix
//
// one number at a time: each digit takes one pass of the bit-serial divider over
// all VALUE_BITS bits of the value, then each character goes out through the
// registered digit store read
// an invalid radix gives a single empty beat
// asynchronous active-low reset; radix returns to 10, digit store is not cleared
// output stall holds the output register and pauses the sign and emit steps; the digit store holds the rest

module integer_to_radix_ascii_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [itoa_pkg::RADIX_W-1:0]    cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [itoa_pkg::NUMBER_W-1:0]   number,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]     char_code,
    output logic                            is_last,
    output logic                            is_empty
);
    import itoa_pkg::*;

    itoa_state_t state_reg, state_next;

    logic [RADIX_W-1:0]    radix_reg;
    logic [CNT_W-1:0]      digit_cnt_reg, digit_cnt_next;
    logic                  neg_reg, neg_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [DIGIT_W-1:0]    rd_data_reg;

    // output register, parts the emit logic from the downstream stall
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  empty_reg, empty_next;
    logic                  out_load;
    logic                  out_free;

    // digit store, least significant digit at index 0
    logic [DIGIT_W-1:0]    digit_store [VALUE_BITS];

    logic                  in_accept;
    logic                  radix_ok;
    logic [VALUE_BITS-1:0] raw;
    logic                  raw_neg;
    logic [VALUE_BITS-1:0] mag;
    logic                  div_start;
    itoa_div_status_t      div_status;

    assign in_stall  = state_reg != ST_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign radix_ok  = (radix_reg >= MIN_RADIX) && (radix_reg <= MAX_RADIX);
    assign raw       = number[VALUE_BITS-1:0];
    assign raw_neg   = raw[VALUE_BITS-1];
    // unsigned magnitude, so the most negative value stays correct
    assign mag       = raw_neg ? (~raw + VALUE_BITS'(1)) : raw;
    assign out_free  = !out_valid_reg || !out_stall;

    assign div_start = in_accept && radix_ok;

    itoa_div_serial u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .value  (mag),
        .radix  (radix_reg),
        .status (div_status)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = radix_ok ? ST_DIVIDE : ST_EMPTY;
            end
            ST_EMPTY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                    state_next = neg_reg ? ST_SIGN : ST_READ;
            end
            ST_SIGN:
            begin
                // read of the top digit completes while the sign waits
                if (out_free)
                    state_next = ST_EMIT;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = (rd_idx_reg == '0) ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output beat selection
    always_comb
    begin
        digit_cnt_next = digit_cnt_reg;
        neg_next       = neg_reg;
        rd_idx_next    = rd_idx_reg;
        out_load       = 1'b0;
        char_next      = char_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    digit_cnt_next = '0;
                    neg_next       = radix_ok && raw_neg;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = EMPTY_CODE;
                    last_next  = 1'b1;
                    empty_next = 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.digit_valid)
                    digit_cnt_next = digit_cnt_reg + CNT_W'(1);
                // top digit sits at the slot being written now
                if (div_status.done)
                    rd_idx_next = digit_cnt_reg[IDX_W-1:0];
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = MINUS_CODE;
                    last_next  = 1'b0;
                    empty_next = 1'b0;
                end
            end
            ST_READ:
            begin
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = digit_char(rd_data_reg);
                    last_next  = rd_idx_reg == '0;
                    empty_next = 1'b0;
                    if (rd_idx_reg != '0)
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            digit_cnt_reg <= '0;
            neg_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digit_cnt_reg <= digit_cnt_next;
            neg_reg       <= neg_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                radix_reg <= cfg_wr_data;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

    // digit store: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (div_status.digit_valid)
            digit_store[digit_cnt_reg[IDX_W-1:0]] <= div_status.digit;
        rd_data_reg <= digit_store[rd_idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign is_last   = last_reg;
    assign is_empty  = empty_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && empty_reg |-> last_reg)
        else $error("empty beat not flagged last");

    a_digit_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.digit_valid |-> state_reg == ST_DIVIDE)
        else $error("divider digit outside divide phase");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_cnt_reg <= CNT_W'(VALUE_BITS))
        else $error("digit count beyond store depth");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != ST_IDLE)
        else $error("accepted number did not start work");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(char_reg) && $stable(last_reg))
        else $error("stalled output beat changed");

endmodule
